>>> rtl/core/pgsd_pkg.sv
`timescale 1ns / 1ps

package pgsd_pkg;

   // Column limit; the configured count saturates here.
   localparam int MAX_COLUMNS = 2048;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CNT_W       = 12;

   // Front-to-back queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Header layout, in bytes.
   localparam logic [4:0] SIG_LEN       = 5'd11;
   localparam logic [4:0] FLAGS_LAST    = 5'd14;
   localparam logic [4:0] HDR_LAST      = 5'd18;
   localparam logic [1:0] FLEN_LAST     = 2'd3;
   localparam logic [15:0] TRAILER_WORD = 16'hFFFF;
   localparam logic [31:0] NULL_LENGTH  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      EV_BYTE  = 3'd0,
      EV_NULL  = 3'd1,
      EV_EMPTY = 3'd2,
      EV_DONE  = 3'd3,
      EV_ERROR = 3'd4
   } evt_type;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_SIGNATURE    = 4'd1,
      ERR_OIDS         = 4'd2,
      ERR_CRITICAL     = 4'd3,
      ERR_NEG_EXT      = 4'd4,
      ERR_TRUNC_EXT    = 4'd5,
      ERR_TRUNC_ROWHDR = 4'd6,
      ERR_COUNT        = 4'd7,
      ERR_TRUNC_LENGTH = 4'd8,
      ERR_NEG_LENGTH   = 4'd9,
      ERR_TRUNC_VALUE  = 4'd10,
      ERR_AFTER_TRAIL  = 4'd11
   } err_type;

   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      evt_type          evt;
      logic [COL_W-1:0] column;
      logic [7:0]       payload;
      logic             field_last;
      logic             row_last;
      err_type          err;
   } result_type;

   // Expected signature byte at a header position.
   function automatic logic [7:0] sig_byte(input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         4'd0:    b = 8'h50;
         4'd1:    b = 8'h47;
         4'd2:    b = 8'h43;
         4'd3:    b = 8'h4F;
         4'd4:    b = 8'h50;
         4'd5:    b = 8'h59;
         4'd6:    b = 8'h0A;
         4'd7:    b = 8'hFF;
         4'd8:    b = 8'h0D;
         4'd9:    b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/pgsd_front.sv
`timescale 1ns / 1ps

module pgsd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [7:0]         req_data_byte,
   input  logic               q_full,
   output logic               push,
   output pgsd_pkg::item_type item
);

   logic               hold_valid_ff, hold_valid_in;
   pgsd_pkg::item_type hold_item_ff, hold_item_in;
   logic               accept;

   assign push      = hold_valid_ff && !q_full;
   assign req_stall = hold_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign item      = hold_item_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (accept) begin
         hold_valid_in       = 1'b1;
         hold_item_in.is_end = req_kind;
         // data byte means nothing on an end marker
         hold_item_in.data   = req_kind ? 8'h00 : req_data_byte;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

>>> rtl/core/pgsd_queue.sv
`timescale 1ns / 1ps

module pgsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pgsd_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pgsd_pkg::item_type head_item
);

   pgsd_pkg::item_type                 slot_ff [pgsd_pkg::QUEUE_DEPTH];
   logic [pgsd_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pgsd_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pgsd_pkg::QUEUE_AW:0]        count_ff, count_in;

   assign full       = (count_ff == (pgsd_pkg::QUEUE_AW+1)'(pgsd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/pgsd_parse.sv
`timescale 1ns / 1ps

module pgsd_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pgsd_pkg::CNT_W-1:0]   csr_column_count,
   input  logic                         head_valid,
   input  pgsd_pkg::item_type           head_item,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_stall,
   output pgsd_pkg::result_type         out_res
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_HDR_OIDS,
      PH_HDR_CRIT,
      PH_EXT,
      PH_ROWHDR,
      PH_FLEN,
      PH_FDATA,
      PH_TRAILER
   } phase_type;

   localparam logic [pgsd_pkg::CNT_W-1:0] MAX_CNT = pgsd_pkg::CNT_W'(pgsd_pkg::MAX_COLUMNS);

   phase_type                       phase_ff, phase_in;
   logic [4:0]                      pos_ff, pos_in;
   logic [31:0]                     shift_ff, shift_in;
   logic                            sig_bad_ff, sig_bad_in;
   logic [30:0]                     ext_rem_ff, ext_rem_in;
   logic [pgsd_pkg::COL_W-1:0]      col_ff, col_in;
   logic [30:0]                     fld_rem_ff, fld_rem_in;
   logic                            halted_ff, halted_in;
   logic [pgsd_pkg::CNT_W-1:0]      ncol_ff, ncol_in;
   logic                            out_valid_ff, out_valid_in;
   pgsd_pkg::result_type            res_ff, res_in;

   logic                            take;
   logic                            emit;
   pgsd_pkg::result_type            res;
   logic [7:0]                      b;
   logic [31:0]                     shifted;
   logic [15:0]                     w16;
   logic [30:0]                     ext_dec;
   logic [30:0]                     fld_dec;
   logic [pgsd_pkg::CNT_W-1:0]      col_inc;
   logic                            row_end;

   assign take      = !out_valid_ff || !out_stall;
   assign pop       = take && head_valid;
   assign out_valid = out_valid_ff;
   assign out_res   = res_ff;

   assign b       = head_item.data;
   assign shifted = {shift_ff[23:0], b};
   assign w16     = {shift_ff[7:0], b};
   assign ext_dec = ext_rem_ff - 31'd1;
   assign fld_dec = fld_rem_ff - 31'd1;
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_end = (col_inc >= ncol_ff);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      shift_in   = shift_ff;
      sig_bad_in = sig_bad_ff;
      ext_rem_in = ext_rem_ff;
      col_in     = col_ff;
      fld_rem_in = fld_rem_ff;
      halted_in  = halted_ff;
      ncol_in    = ncol_ff;
      emit       = 1'b0;
      res        = '0;
      res.evt    = pgsd_pkg::EV_BYTE;
      res.err    = pgsd_pkg::ERR_NONE;

      // saturate once at write time
      if (csr_wr_en) begin
         ncol_in = (csr_column_count > MAX_CNT) ? MAX_CNT : csr_column_count;
      end

      if (pop && !halted_ff) begin
         if (head_item.is_end) begin
            emit      = 1'b1;
            halted_in = 1'b1;
            res.evt   = pgsd_pkg::EV_ERROR;
            case (phase_ff)
               PH_HEADER, PH_HDR_OIDS, PH_HDR_CRIT: begin
                  if (pos_ff == '0) begin
                     res.evt = pgsd_pkg::EV_DONE;
                  end else begin
                     res.err = pgsd_pkg::ERR_SIGNATURE;
                  end
               end
               PH_EXT:   res.err = pgsd_pkg::ERR_TRUNC_EXT;
               PH_ROWHDR: begin
                  if (pos_ff == '0) begin
                     res.evt = pgsd_pkg::EV_DONE;
                  end else begin
                     res.err = pgsd_pkg::ERR_TRUNC_ROWHDR;
                  end
               end
               PH_FLEN:  res.err = pgsd_pkg::ERR_TRUNC_LENGTH;
               PH_FDATA: res.err = pgsd_pkg::ERR_TRUNC_VALUE;
               default:  res.evt = pgsd_pkg::EV_DONE;
            endcase
         end else begin
            case (phase_ff)
               PH_HEADER, PH_HDR_OIDS, PH_HDR_CRIT: begin
                  if (pos_ff < pgsd_pkg::SIG_LEN) begin
                     if (b != pgsd_pkg::sig_byte(pos_ff[3:0])) begin
                        sig_bad_in = 1'b1;
                     end
                  end else begin
                     shift_in = shifted;
                  end
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff == pgsd_pkg::FLAGS_LAST) begin
                     if (shifted[16]) begin
                        phase_in = PH_HDR_OIDS;
                     end else if (shifted[31:17] != '0) begin
                        phase_in = PH_HDR_CRIT;
                     end
                     shift_in = '0;
                  end else if (pos_ff == pgsd_pkg::HDR_LAST) begin
                     // checks in order: signature, OID flag, critical flags, ext sign
                     if (sig_bad_ff) begin
                        emit    = 1'b1;
                        res.evt = pgsd_pkg::EV_ERROR;
                        res.err = pgsd_pkg::ERR_SIGNATURE;
                     end else if (phase_ff == PH_HDR_OIDS) begin
                        emit    = 1'b1;
                        res.evt = pgsd_pkg::EV_ERROR;
                        res.err = pgsd_pkg::ERR_OIDS;
                     end else if (phase_ff == PH_HDR_CRIT) begin
                        emit    = 1'b1;
                        res.evt = pgsd_pkg::EV_ERROR;
                        res.err = pgsd_pkg::ERR_CRITICAL;
                     end else if (shifted[31]) begin
                        emit    = 1'b1;
                        res.evt = pgsd_pkg::EV_ERROR;
                        res.err = pgsd_pkg::ERR_NEG_EXT;
                     end else begin
                        ext_rem_in = shifted[30:0];
                        shift_in   = '0;
                        pos_in     = '0;
                        phase_in   = (shifted[30:0] != '0) ? PH_EXT : PH_ROWHDR;
                     end
                     halted_in = emit;
                  end
               end
               PH_EXT: begin
                  ext_rem_in = ext_dec;
                  if (ext_dec == '0) begin
                     phase_in = PH_ROWHDR;
                  end
               end
               PH_ROWHDR: begin
                  shift_in = {16'h0000, w16};
                  if (pos_ff == '0) begin
                     pos_in = 5'd1;
                  end else begin
                     pos_in = '0;
                     if (w16 == pgsd_pkg::TRAILER_WORD) begin
                        phase_in = PH_TRAILER;
                     end else if (w16 != {4'h0, ncol_ff}) begin
                        emit      = 1'b1;
                        halted_in = 1'b1;
                        res.evt   = pgsd_pkg::EV_ERROR;
                        res.err   = pgsd_pkg::ERR_COUNT;
                     end else begin
                        shift_in = '0;
                        // zero-column rows carry nothing
                        if (ncol_ff != '0) begin
                           col_in   = '0;
                           phase_in = PH_FLEN;
                        end
                     end
                  end
               end
               PH_FLEN: begin
                  shift_in = shifted;
                  pos_in   = pos_ff + 1'b1;
                  if (pos_ff[1:0] == pgsd_pkg::FLEN_LAST) begin
                     res.column = col_ff;
                     if (shifted == pgsd_pkg::NULL_LENGTH || shifted == '0) begin
                        emit           = 1'b1;
                        res.evt        = shifted[31] ? pgsd_pkg::EV_NULL
                                                     : pgsd_pkg::EV_EMPTY;
                        res.field_last = 1'b1;
                        res.row_last   = row_end;
                        pos_in         = '0;
                        shift_in       = '0;
                        if (row_end) begin
                           phase_in = PH_ROWHDR;
                        end else begin
                           col_in   = col_inc[pgsd_pkg::COL_W-1:0];
                           phase_in = PH_FLEN;
                        end
                     end else if (shifted[31]) begin
                        emit       = 1'b1;
                        halted_in  = 1'b1;
                        res.evt    = pgsd_pkg::EV_ERROR;
                        res.err    = pgsd_pkg::ERR_NEG_LENGTH;
                        res.column = '0;
                     end else begin
                        fld_rem_in = shifted[30:0];
                        shift_in   = '0;
                        pos_in     = '0;
                        phase_in   = PH_FDATA;
                     end
                  end
               end
               PH_FDATA: begin
                  emit        = 1'b1;
                  res.evt     = pgsd_pkg::EV_BYTE;
                  res.column  = col_ff;
                  res.payload = b;
                  fld_rem_in  = fld_dec;
                  if (fld_dec == '0) begin
                     res.field_last = 1'b1;
                     res.row_last   = row_end;
                     pos_in         = '0;
                     shift_in       = '0;
                     if (row_end) begin
                        phase_in = PH_ROWHDR;
                     end else begin
                        col_in   = col_inc[pgsd_pkg::COL_W-1:0];
                        phase_in = PH_FLEN;
                     end
                  end
               end
               default: begin
                  emit      = 1'b1;
                  halted_in = 1'b1;
                  res.evt   = pgsd_pkg::EV_ERROR;
                  res.err   = pgsd_pkg::ERR_AFTER_TRAIL;
               end
            endcase
         end
      end

      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (take) begin
         out_valid_in = pop && emit;
         res_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         shift_ff     <= '0;
         sig_bad_ff   <= 1'b0;
         ext_rem_ff   <= '0;
         col_ff       <= '0;
         fld_rem_ff   <= '0;
         halted_ff    <= 1'b0;
         ncol_ff      <= pgsd_pkg::CNT_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         sig_bad_ff   <= sig_bad_in;
         ext_rem_ff   <= ext_rem_in;
         col_ff       <= col_in;
         fld_rem_ff   <= fld_rem_in;
         halted_ff    <= halted_in;
         ncol_ff      <= ncol_in;
         out_valid_ff <= out_valid_in;
      end
      res_ff <= res_in;
   end

endmodule

>>> rtl/core/pgcopy_binary_stream_deframer_core.sv
`timescale 1ns / 1ps

// Binary COPY stream deframer. Takes the stream one byte per transfer on the
// req_ channel (req_kind 0 = data byte, 1 = end of stream) and emits at most
// one event per input on the rsp_ channel: field payload bytes tagged with
// column, field_last and row_last, null and empty field markers, a clean
// finish, or an error with its code. The 19-byte header (signature, flags,
// extension length) is checked when its last byte arrives; extension bytes
// are skipped; each row must declare csr_column_count fields (values above
// 2048 saturate) or the trailer word. After a finish or error the block
// swallows every further input without a response until reset. Throughput is
// one input byte per clock while rsp_stall is low: a registered front stage
// feeds a four-entry queue, and the byte-at-a-time parser drains one entry
// per clock into a single output register, so an input transfer passes the
// front stage, a queue entry and the output register before its response
// appears. A rsp_stall backs up the queue before req_stall rises. Write
// csr_column_count only while no transfer is in flight; it resets to 1.

module pgcopy_binary_stream_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_column_count,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [10:0] rsp_column,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_field_last,
   output logic        rsp_row_last,
   output logic [3:0]  rsp_error_code
);

   // front stage -> queue
   logic                 push;
   pgsd_pkg::item_type   push_item;
   logic                 q_full;
   // queue -> parser
   logic                 pop;
   logic                 head_valid;
   pgsd_pkg::item_type   head_item;
   pgsd_pkg::result_type res;

   pgsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .push          (push),
      .item          (push_item)
   );

   pgsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   pgsd_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_column_count (csr_column_count),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .out_valid        (rsp_valid),
      .out_stall        (rsp_stall),
      .out_res          (res)
   );

   // unpack the result register onto the ports
   assign rsp_event_res    = res.evt;
   assign rsp_column       = res.column;
   assign rsp_payload_byte = res.payload;
   assign rsp_field_last   = res.field_last;
   assign rsp_row_last     = res.row_last;
   assign rsp_error_code   = res.err;

endmodule

>>> rtl/core/pgsd_checker.sv
`timescale 1ns / 1ps

module pgsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [10:0] rsp_column,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_field_last,
   input logic        rsp_row_last,
   input logic [3:0]  rsp_error_code
);

   logic ended_ff, ended_in;

   // a finish or error transfer ends the stream
   assign ended_in = ended_ff || (rsp_valid && !rsp_stall &&
                     (rsp_event_res == pgsd_pkg::EV_DONE ||
                      rsp_event_res == pgsd_pkg::EV_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) &&
      $stable(rsp_column) && $stable(rsp_payload_byte) && $stable(rsp_error_code) &&
      $stable(rsp_field_last) && $stable(rsp_row_last))
      else $error("stalled response changed");

   a_sticky_end: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> !rsp_valid)
      else $error("response after finish or error");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_res == pgsd_pkg::EV_ERROR) == (rsp_error_code != '0)))
      else $error("error code does not match event");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == pgsd_pkg::EV_NULL ||
                    rsp_event_res == pgsd_pkg::EV_EMPTY) |-> rsp_field_last)
      else $error("null or empty field without field_last");

endmodule

bind pgcopy_binary_stream_deframer_core pgsd_checker u_pgsd_checker (.*);
